// File: hw/rtl/ghcc_pkg.sv
// ghcc_pkg: shared codes, widths and the command record for the gated hit
// coincidence counter. No dependencies.
package ghcc_pkg;

    // Fixed field widths of the ports
    localparam int OPCODE_W    = 2;
    localparam int GATE_IDX_W  = 4;
    localparam int BOUND_IDX_W = 2;
    localparam int SAMPLE_W    = 16;
    localparam int COUNT_W     = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int DIM_W       = 2;
    localparam int GATES_W     = 5;

    // Queue depths between the parts
    localparam int CMD_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    // Request opcodes
    localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_HIT   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GATES  = 2'd2;

    // Gate dimension codes
    localparam logic [DIM_W-1:0] DIM_1D = 2'd1;
    localparam logic [DIM_W-1:0] DIM_2D = 2'd2;

    // Work the back end performs for one request
    typedef enum logic [2:0] {
        CMD_LOAD,
        CMD_HIT1,
        CMD_HIT2,
        CMD_STORE,
        CMD_READ,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [GATE_IDX_W-1:0]  gate;
        logic [BOUND_IDX_W-1:0] bound;
        logic                   first;
        logic                   in_range;
    } cmd_t;

endpackage

// File: hw/rtl/ghcc_fifo.sv
// ghcc_fifo: small flop-based queue, used between front and back and for
// results. No dependencies.
module ghcc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// File: hw/rtl/ghcc_front.sv
// ghcc_front: configuration registers and request classification.
// Depends on ghcc_pkg.
module ghcc_front #(
    parameter int MAX_GATES  = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ghcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ghcc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            push,
    input  logic                            q_full,
    input  logic [ghcc_pkg::OPCODE_W-1:0]   opcode,
    input  logic [ghcc_pkg::GATE_IDX_W-1:0] gate_index,
    input  logic [ghcc_pkg::BOUND_IDX_W-1:0] bound_index,
    input  logic [ghcc_pkg::SAMPLE_W-1:0]   sample_value,
    input  logic                            first_of_event,
    output logic                            cmd_wr,
    output ghcc_pkg::cmd_t                  cmd,
    output logic [VALUE_BITS-1:0]           cmd_value,
    output logic [ghcc_pkg::GATES_W-1:0]    gates_in_use
);
    import ghcc_pkg::*;

    logic                   enabled_reg;
    logic [DIM_W-1:0]       dim_reg;
    logic [GATES_W-1:0]     gates_reg;
    logic                   keep;
    logic                   gate_ok;
    logic [VALUE_BITS+SAMPLE_W-1:0] value_ext;

    assign cfg_ready    = 1'b1;
    assign gates_in_use = gates_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            dim_reg     <= DIM_1D;
            gates_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ENABLE: enabled_reg <= cfg_data[0];
                CFG_DIM:    dim_reg     <= cfg_data[DIM_W-1:0];
                CFG_GATES:  gates_reg   <= cfg_data[GATES_W-1:0];
                default:    ;
            endcase
        end
    end

    // Value masked to VALUE_BITS
    assign value_ext = {{VALUE_BITS{1'b0}}, sample_value};
    assign cmd_value = value_ext[VALUE_BITS-1:0];
    assign gate_ok   = (32'(gate_index) < MAX_GATES);

    // Classify the request; dropped ones are accepted but not queued
    always_comb
    begin
        cmd.gate     = gate_index;
        cmd.bound    = bound_index;
        cmd.first    = first_of_event;
        cmd.in_range = gate_ok;
        cmd.kind     = CMD_CLEAR;
        keep         = 1'b1;
        case (opcode)
            OP_LOAD:
            begin
                cmd.kind = CMD_LOAD;
                keep     = gate_ok;
            end
            OP_HIT:
            begin
                keep = enabled_reg;
                if (dim_reg == DIM_1D)
                    cmd.kind = CMD_HIT1;
                else if (dim_reg == DIM_2D)
                    cmd.kind = CMD_HIT2;
                else
                    cmd.kind = CMD_STORE;
            end
            OP_READ:  cmd.kind = CMD_READ;
            default:  cmd.kind = CMD_CLEAR;
        endcase
    end

    assign cmd_wr = push && !q_full && keep;

endmodule

// File: hw/rtl/ghcc_back.sv
// ghcc_back: gate bounds, counters, event hit memory and the pair pipeline.
// Depends on ghcc_pkg.
module ghcc_back #(
    parameter int MAX_GATES  = 16,
    parameter int MAX_FOLD   = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_empty,
    input  ghcc_pkg::cmd_t                  cmd,
    input  logic [VALUE_BITS-1:0]           cmd_value,
    output logic                            cmd_pop,
    input  logic [ghcc_pkg::GATES_W-1:0]    gates_in_use,
    input  logic                            out_full,
    output logic                            res_wr,
    output logic [ghcc_pkg::GATE_IDX_W-1:0] res_gate,
    output logic [ghcc_pkg::COUNT_W-1:0]    res_count
);
    import ghcc_pkg::*;

    localparam int GW = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
    localparam int AW = $clog2(MAX_FOLD);
    localparam int CW = $clog2(MAX_FOLD + 1);

    typedef enum logic {S_IDLE, S_PAIR} state_t;

    function automatic logic in_window(input logic [VALUE_BITS-1:0] v,
                                       input logic [VALUE_BITS-1:0] b1,
                                       input logic [VALUE_BITS-1:0] b2);
        if (b1 > b2)
            return (v >= b2) && (v < b1);
        else if (b2 > b1)
            return (v >= b1) && (v < b2);
        else
            return v == b1;
    endfunction

    state_t                 state_reg;
    logic [AW-1:0]          pair_idx_reg;
    logic [CW-1:0]          pair_total_reg;
    logic [CW-1:0]          cnt_reg;
    logic [VALUE_BITS-1:0]  cur_val_reg;
    logic                   s1_valid_reg;
    logic                   s1_pair_reg;
    logic                   s2_valid_reg;
    logic                   s2_pair_reg;
    logic [MAX_GATES-1:0]   s2_mask_reg;
    logic [VALUE_BITS-1:0]  rd_data_reg;
    logic [VALUE_BITS-1:0]  bounds_reg [MAX_GATES][4];
    logic [COUNT_W-1:0]     counters_reg [MAX_GATES];
    logic [VALUE_BITS-1:0]  hit_mem [MAX_FOLD];

    logic                   take;
    logic                   is_hit;
    logic [CW-1:0]          eff_cnt;
    logic                   mem_we;
    logic                   mem_re;
    logic                   pair_last;
    logic [GW+GATE_IDX_W-1:0] gate_ext;
    logic [GW-1:0]          gsel;
    logic [MAX_GATES-1:0]   match1d;
    logic [MAX_GATES-1:0]   match2d;
    logic [MAX_GATES-1:0]   first2d;

    // Issue: only with the pair pipeline empty; reads also wait for result room
    assign take = (state_reg == S_IDLE) && !cmd_empty && !s1_valid_reg && !s2_valid_reg
                  && !((cmd.kind == CMD_READ) && out_full);
    assign cmd_pop = take;
    assign is_hit  = (cmd.kind == CMD_HIT1) || (cmd.kind == CMD_HIT2) ||
                     (cmd.kind == CMD_STORE);
    assign eff_cnt = cmd.first ? '0 : cnt_reg;
    assign mem_we  = take && is_hit && (eff_cnt < CW'(MAX_FOLD));
    assign mem_re  = (state_reg == S_PAIR);
    assign pair_last = ((CW'(pair_idx_reg) + CW'(1)) == pair_total_reg);

    assign gate_ext = {{GW{1'b0}}, cmd.gate};
    assign gsel     = gate_ext[GW-1:0];

    // Read results
    assign res_wr    = take && (cmd.kind == CMD_READ);
    assign res_gate  = cmd.gate;
    assign res_count = cmd.in_range ? counters_reg[gsel] : '0;

    // Event hit memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hit_mem[eff_cnt[AW-1:0]] <= cmd_value;
        end
        if (mem_re)
        begin
            rd_data_reg <= hit_mem[pair_idx_reg];
        end
    end

    // Gate compare: all gates in parallel
    always_comb
    begin
        for (int g = 0; g < MAX_GATES; g++)
        begin
            match1d[g] = (32'(g) < 32'(gates_in_use)) &&
                         in_window(cur_val_reg, bounds_reg[g][0], bounds_reg[g][1]);
            match2d[g] = (32'(g) < 32'(gates_in_use)) &&
                         ((in_window(rd_data_reg, bounds_reg[g][0], bounds_reg[g][1]) &&
                           in_window(cur_val_reg, bounds_reg[g][2], bounds_reg[g][3])) ||
                          (in_window(rd_data_reg, bounds_reg[g][2], bounds_reg[g][3]) &&
                           in_window(cur_val_reg, bounds_reg[g][0], bounds_reg[g][1])));
        end
    end

    // Lowest matching gate wins a pair
    assign first2d = match2d & (~match2d + MAX_GATES'(1));

    // Sequencer and pipeline stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pair_idx_reg   <= '0;
            pair_total_reg <= '0;
            cnt_reg        <= '0;
            cur_val_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            s1_pair_reg    <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s2_pair_reg    <= 1'b0;
            s2_mask_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= (take && (cmd.kind == CMD_HIT1)) || (state_reg == S_PAIR);
            s1_pair_reg  <= (state_reg == S_PAIR);
            s2_valid_reg <= s1_valid_reg;
            s2_pair_reg  <= s1_pair_reg;
            s2_mask_reg  <= s1_pair_reg ? first2d : match1d;
            case (state_reg)
                S_IDLE:
                begin
                    if (take && is_hit)
                    begin
                        cur_val_reg <= cmd_value;
                        cnt_reg     <= (eff_cnt < CW'(MAX_FOLD)) ? eff_cnt + CW'(1)
                                                                 : eff_cnt;
                        if ((cmd.kind == CMD_HIT2) && (eff_cnt != '0))
                        begin
                            state_reg      <= S_PAIR;
                            pair_idx_reg   <= '0;
                            pair_total_reg <= eff_cnt;
                        end
                    end
                end
                S_PAIR:
                begin
                    pair_idx_reg <= pair_idx_reg + AW'(1);
                    if (pair_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Window bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < MAX_GATES; g++)
                for (int b = 0; b < 4; b++)
                    bounds_reg[g][b] <= '0;
        end
        else if (take && (cmd.kind == CMD_LOAD))
        begin
            bounds_reg[gsel][cmd.bound] <= cmd_value;
        end
    end

    // Saturating counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < MAX_GATES; g++)
                counters_reg[g] <= '0;
        end
        else if (take && (cmd.kind == CMD_CLEAR))
        begin
            for (int g = 0; g < MAX_GATES; g++)
                counters_reg[g] <= '0;
        end
        else if (s2_valid_reg)
        begin
            for (int g = 0; g < MAX_GATES; g++)
                if (s2_mask_reg[g] && (counters_reg[g] != '1))
                    counters_reg[g] <= counters_reg[g] + COUNT_W'(1);
        end
    end

    // A pair bumps at most one gate
    a_pair_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_pair_reg) |-> $onehot0(s2_mask_reg))
        else $error("pair bumps more than one gate");

    // Pair index stays below the stored hit count
    a_pair_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAIR) |-> (CW'(pair_idx_reg) < pair_total_reg))
        else $error("pair index out of range");

    // Event hit count never exceeds the fold depth
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_FOLD))
        else $error("event hit count overflow");

    // Reads and clears only see a drained pipeline
    a_read_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (cmd.kind == CMD_READ || cmd.kind == CMD_CLEAR)) |->
        (!s1_valid_reg && !s2_valid_reg && state_reg == S_IDLE))
        else $error("read or clear while pairs in flight");

endmodule

// File: hw/rtl/gated_hit_coincidence_counter.sv
// gated_hit_coincidence_counter: top level, joins front, request queue,
// back end and result queue. Depends on ghcc_pkg, ghcc_front, ghcc_fifo, ghcc_back.
//
// Usage:
//   Requests enter through push/full and are accepted when push is high and
//   full is low. A request loads a gate bound, presents a hit, reads a gate
//   count or clears all counts. Only reads produce a result, which waits on
//   read_gate/gate_count while empty is low and leaves on pop.
//   Configuration writes use cfg_valid/cfg_ready (always ready), with
//   cfg_index selecting enable, gate dimension or gates in use; write them
//   only while the block is idle.
//   In the back end, a 1D hit is compared against the gates and then counted;
//   a 2D hit with stored earlier hits of the event is paired with each of them
//   in turn by the single pair compare unit, one stored hit per cycle; with no
//   stored hit it is only stored. The back end takes no new request until the
//   pair pipeline is empty; a read result goes out through the result queue.
//   Reset clears bounds, counters, the event hit count and both queues.
//   If the result queue is full, a read waits in the back end and the request
//   queue fills; full then rises and holds off new requests.
module gated_hit_coincidence_counter #(
    parameter int MAX_GATES  = 16,
    parameter int MAX_FOLD   = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [ghcc_pkg::OPCODE_W-1:0]    opcode,
    input  logic [ghcc_pkg::GATE_IDX_W-1:0]  gate_index,
    input  logic [ghcc_pkg::BOUND_IDX_W-1:0] bound_index,
    input  logic [ghcc_pkg::SAMPLE_W-1:0]    sample_value,
    input  logic                             first_of_event,
    output logic                             empty,
    input  logic                             pop,
    output logic [ghcc_pkg::GATE_IDX_W-1:0]  read_gate,
    output logic [ghcc_pkg::COUNT_W-1:0]     gate_count,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ghcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ghcc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ghcc_pkg::*;

    localparam int CMD_BITS = $bits(cmd_t) + VALUE_BITS;
    localparam int RES_BITS = GATE_IDX_W + COUNT_W;

    logic                   cmd_wr;
    cmd_t                   f_cmd;
    logic [VALUE_BITS-1:0]  f_value;
    logic [GATES_W-1:0]     gates_in_use;
    logic                   cmd_full;
    logic                   cmd_empty;
    logic                   cmd_pop;
    logic [CMD_BITS-1:0]    q_data;
    cmd_t                   q_cmd;
    logic [VALUE_BITS-1:0]  q_value;
    logic                   out_full;
    logic                   res_wr;
    logic [GATE_IDX_W-1:0]  res_gate;
    logic [COUNT_W-1:0]     res_count;
    logic [RES_BITS-1:0]    out_data;

    assign full = cmd_full;

    // Front: config and classification
    ghcc_front #(
        .MAX_GATES  (MAX_GATES),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .q_full         (cmd_full),
        .opcode         (opcode),
        .gate_index     (gate_index),
        .bound_index    (bound_index),
        .sample_value   (sample_value),
        .first_of_event (first_of_event),
        .cmd_wr         (cmd_wr),
        .cmd            (f_cmd),
        .cmd_value      (f_value),
        .gates_in_use   (gates_in_use)
    );

    // Request queue between front and back
    ghcc_fifo #(
        .WIDTH (CMD_BITS),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_wr),
        .wr_data ({f_cmd, f_value}),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (q_data),
        .empty   (cmd_empty)
    );

    assign {q_cmd, q_value} = q_data;

    // Back: bounds, counters and pair pipeline
    ghcc_back #(
        .MAX_GATES  (MAX_GATES),
        .MAX_FOLD   (MAX_FOLD),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_empty    (cmd_empty),
        .cmd          (q_cmd),
        .cmd_value    (q_value),
        .cmd_pop      (cmd_pop),
        .gates_in_use (gates_in_use),
        .out_full     (out_full),
        .res_wr       (res_wr),
        .res_gate     (res_gate),
        .res_count    (res_count)
    );

    // Result queue
    ghcc_fifo #(
        .WIDTH (RES_BITS),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data ({res_gate, res_count}),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (out_data),
        .empty   (empty)
    );

    assign {read_gate, gate_count} = out_data;

endmodule

// File: test/tb_gated_hit_coincidence_counter.sv
// tb_gated_hit_coincidence_counter: self-checking bench for the gated hit coincidence
// counter. Depends on ghcc_pkg and the gated_hit_coincidence_counter RTL.
module tb_gated_hit_coincidence_counter;
    import ghcc_pkg::*;

    localparam int GATE_COUNT  = 16;
    localparam int FOLD_DEPTH  = 16;
    localparam int DRAIN_WAIT  = 64;   // covers a full fold hit plus both queues
    localparam int STALL_LIMIT = 2000;

    // Dimension codes the block stores but does not count with
    localparam logic [DIM_W-1:0] DIM_NONE  = 2'd0;
    localparam logic [DIM_W-1:0] DIM_SPARE = 2'd3;

    typedef struct {
        logic [GATE_IDX_W-1:0] gate;
        logic [COUNT_W-1:0]    count;
    } count_reply_t;

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    logic [OPCODE_W-1:0]    opcode;
    logic [GATE_IDX_W-1:0]  gate_index;
    logic [BOUND_IDX_W-1:0] bound_index;
    logic [SAMPLE_W-1:0]    sample_value;
    logic                   first_of_event;
    logic                   empty;
    logic                   pop;
    logic [GATE_IDX_W-1:0]  read_gate;
    logic [COUNT_W-1:0]     gate_count;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Mirror of the block state
    logic [SAMPLE_W-1:0]   bounds [GATE_COUNT*4];
    logic [COUNT_W-1:0]    counts [GATE_COUNT];
    logic [SAMPLE_W-1:0]   ev_hits [FOLD_DEPTH];
    int unsigned           ev_fill;
    logic                  count_on;
    logic [DIM_W-1:0]      dim_cfg;
    logic [GATES_W-1:0]    gates_cfg;

    count_reply_t pending_counts [$];
    int unsigned  errors;
    int unsigned  quiet_cycles;
    bit           idle_on;
    bit           stall_on;

    gated_hit_coincidence_counter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .opcode         (opcode),
        .gate_index     (gate_index),
        .bound_index    (bound_index),
        .sample_value   (sample_value),
        .first_of_event (first_of_event),
        .empty          (empty),
        .pop            (pop),
        .read_gate      (read_gate),
        .gate_count     (gate_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- gate arithmetic ----------------

    // Lower bound inclusive, upper exclusive, either order; equal bounds match one value
    function automatic bit window_holds(logic [SAMPLE_W-1:0] v, logic [SAMPLE_W-1:0] b1,
                                        logic [SAMPLE_W-1:0] b2);
        if (b1 > b2)
            return (v >= b2) && (v < b1);
        if (b2 > b1)
            return (v >= b1) && (v < b2);
        return v == b1;
    endfunction

    function automatic int unsigned live_gates();
        return (gates_cfg > GATE_COUNT) ? GATE_COUNT : gates_cfg;
    endfunction

    function automatic void bump_count(int unsigned g);
        if (counts[g] != '1)
            counts[g] = counts[g] + 1;
    endfunction

    // Only the lowest matching gate takes the pair
    function automatic void count_coincidence(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
        int unsigned g;
        for (g = 0; g < live_gates(); g++)
        begin
            if ((window_holds(a, bounds[g*4], bounds[g*4+1]) &&
                 window_holds(b, bounds[g*4+2], bounds[g*4+3])) ||
                (window_holds(a, bounds[g*4+2], bounds[g*4+3]) &&
                 window_holds(b, bounds[g*4], bounds[g*4+1])))
            begin
                bump_count(g);
                return;
            end
        end
    endfunction

    function automatic void apply_hit(logic [SAMPLE_W-1:0] v, logic first);
        int unsigned j;
        if (!count_on)
            return;
        if (first)
            ev_fill = 0;
        if (dim_cfg == DIM_1D)
        begin
            for (j = 0; j < live_gates(); j++)
                if (window_holds(v, bounds[j*4], bounds[j*4+1]))
                    bump_count(j);
        end
        else if (dim_cfg == DIM_2D)
        begin
            for (j = 0; j < ev_fill; j++)
                count_coincidence(ev_hits[j], v);
        end
        // hits past the fold depth still pair but are not kept
        if (ev_fill < FOLD_DEPTH)
        begin
            ev_hits[ev_fill] = v;
            ev_fill++;
        end
    endfunction

    function automatic void predict_request(logic [OPCODE_W-1:0] op,
                                            logic [GATE_IDX_W-1:0] gate,
                                            logic [BOUND_IDX_W-1:0] bound,
                                            logic [SAMPLE_W-1:0] v, logic first);
        count_reply_t reply;
        case (op)
            OP_LOAD:  bounds[{gate, bound}] = v;
            OP_HIT:   apply_hit(v, first);
            OP_READ:
            begin
                reply.gate  = gate;
                reply.count = counts[gate];
                pending_counts.push_back(reply);
            end
            OP_CLEAR: foreach (counts[g]) counts[g] = '0;
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                   input logic [COUNT_W-1:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // ---------------- monitor: prediction, checking, watchdog ----------------

    always @(posedge clk)
    begin : monitor
        count_reply_t want;
        bit           moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                case (cfg_index)
                    CFG_ENABLE: count_on  = cfg_data[0];
                    CFG_DIM:    dim_cfg   = cfg_data[DIM_W-1:0];
                    CFG_GATES:  gates_cfg = cfg_data[GATES_W-1:0];
                    default: ;
                endcase
            end
            if (push && !full)
            begin
                moved = 1'b1;
                predict_request(opcode, gate_index, bound_index, sample_value, first_of_event);
            end
            if (pop && !empty)
            begin
                moved = 1'b1;
                if (pending_counts.size() == 0)
                    report_mismatch("result with no read pending", COUNT_W'(read_gate), '0);
                else
                begin
                    want = pending_counts.pop_front();
                    if (read_gate !== want.gate)
                        report_mismatch("read_gate", COUNT_W'(read_gate), COUNT_W'(want.gate));
                    if (gate_count !== want.count)
                        report_mismatch("gate_count", gate_count, want.count);
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: pop stays high apart from random stall bursts
    initial
    begin : pop_driver
        pop = 1'b1;
        forever
        begin
            @(posedge clk);
            if (stall_on && $urandom_range(0, 5) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                pop <= 1'b1;
            end
        end
    end

    // ---------------- request and register drivers ----------------

    // Present one request and hold it until the block takes it
    task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [GATE_IDX_W-1:0] gate,
                                input logic [BOUND_IDX_W-1:0] bound,
                                input logic [SAMPLE_W-1:0] v, input logic first);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        push           <= 1'b1;
        opcode         <= op;
        gate_index     <= gate;
        bound_index    <= bound;
        sample_value   <= v;
        first_of_event <= first;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Stop sending, wait for every read to return, then let the back end finish
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_mode(input logic en, input logic [DIM_W-1:0] dim,
                            input logic [GATES_W-1:0] gates);
        wait_idle();
        write_register(CFG_ENABLE, CFG_DATA_W'(en));
        write_register(CFG_DIM, CFG_DATA_W'(dim));
        write_register(CFG_GATES, CFG_DATA_W'(gates));
        cfg_valid <= 1'b0;
    endtask

    // ---------------- random request content ----------------

    // Hits land near stored bounds half the time so windows edges get exercised
    function automatic logic [SAMPLE_W-1:0] hit_value();
        logic [SAMPLE_W-1:0] base;
        if ($urandom_range(0, 1) == 0)
            return SAMPLE_W'($urandom);
        base = bounds[$urandom_range(0, GATE_COUNT*4 - 1)];
        return base + SAMPLE_W'($urandom_range(0, 2)) - 1'b1;
    endfunction

    // Bounds often sit near their partner so windows stay narrow
    function automatic logic [SAMPLE_W-1:0] bound_value(logic [GATE_IDX_W-1:0] gate,
                                                       logic [BOUND_IDX_W-1:0] bound);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        if (pick < 6)
            return bounds[{gate, bound ^ 2'd1}] + SAMPLE_W'($urandom_range(0, 4000)) -
                   SAMPLE_W'(2000);
        return SAMPLE_W'($urandom);
    endfunction

    task automatic run_traffic(input int unsigned n_items);
        int unsigned         sent;
        int unsigned         len;
        int unsigned         k;
        int unsigned         pick;
        logic [GATE_IDX_W-1:0]  g;
        logic [BOUND_IDX_W-1:0] b;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                // one event; a few run past the fold depth
                len = ($urandom_range(0, 14) == 0) ? $urandom_range(FOLD_DEPTH + 1, 20)
                                                   : $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                begin
                    send_request(OP_HIT, GATE_IDX_W'($urandom), BOUND_IDX_W'($urandom),
                                 hit_value(), (k == 0) ^ ($urandom_range(0, 19) == 0));
                    sent++;
                end
            end
            else if (pick < 75)
            begin
                g = GATE_IDX_W'($urandom);
                b = BOUND_IDX_W'($urandom);
                send_request(OP_LOAD, g, b, bound_value(g, b), 1'($urandom));
                sent++;
            end
            else if (pick < 97)
            begin
                send_request(OP_READ, GATE_IDX_W'($urandom), BOUND_IDX_W'($urandom),
                             SAMPLE_W'($urandom), 1'($urandom));
                sent++;
            end
            else
            begin
                send_request(OP_CLEAR, GATE_IDX_W'($urandom), BOUND_IDX_W'($urandom),
                             SAMPLE_W'($urandom), 1'($urandom));
                sent++;
            end
        end
    endtask

    // ---------------- tests ----------------

    // Window edges, reversed and equal bounds, reads and clear in 1D mode
    task automatic test_one_value_gates();
        idle_on  = 1'b1;
        stall_on = 1'b1;
        set_mode(1'b1, DIM_1D, GATES_W'(GATE_COUNT));
        send_request(OP_LOAD, 4'd0, 2'd0, 16'd100, 1'b0);
        send_request(OP_LOAD, 4'd0, 2'd1, 16'd200, 1'b0);
        send_request(OP_LOAD, 4'd1, 2'd0, 16'd300, 1'b0);   // reversed bounds
        send_request(OP_LOAD, 4'd1, 2'd1, 16'd250, 1'b0);
        send_request(OP_LOAD, 4'd2, 2'd0, 16'hFFFF, 1'b0);  // exact match at top value
        send_request(OP_LOAD, 4'd2, 2'd1, 16'hFFFF, 1'b0);
        send_request(OP_HIT, 4'd0, 2'd0, 16'd100, 1'b1);
        send_request(OP_HIT, 4'd0, 2'd0, 16'd199, 1'b0);
        send_request(OP_HIT, 4'd0, 2'd0, 16'd200, 1'b0);
        send_request(OP_HIT, 4'd0, 2'd0, 16'd250, 1'b0);
        send_request(OP_HIT, 4'd0, 2'd0, 16'd0, 1'b0);      // gate 3 still 0..0
        send_request(OP_HIT, 4'd0, 2'd0, 16'hFFFF, 1'b0);
        send_request(OP_READ, 4'd0, 2'd0, 16'd0, 1'b0);
        send_request(OP_READ, 4'd1, 2'd0, 16'd0, 1'b0);
        send_request(OP_READ, 4'd2, 2'd0, 16'd0, 1'b0);
        send_request(OP_READ, 4'd3, 2'd0, 16'd0, 1'b0);
        send_request(OP_CLEAR, 4'd0, 2'd0, 16'd0, 1'b0);
        send_request(OP_READ, 4'd0, 2'd0, 16'd0, 1'b0);
    endtask

    // Pairs with the stored hit above and below the new one, one gate per pair
    task automatic test_pair_gates();
        set_mode(1'b1, DIM_2D, GATES_W'(2));
        send_request(OP_LOAD, 4'd0, 2'd2, 16'd150, 1'b0);
        send_request(OP_LOAD, 4'd0, 2'd3, 16'd160, 1'b0);
        send_request(OP_LOAD, 4'd1, 2'd3, 16'hFFFF, 1'b0);
        send_request(OP_HIT, 4'd0, 2'd0, 16'd155, 1'b1);
        send_request(OP_HIT, 4'd0, 2'd0, 16'd120, 1'b0);
        send_request(OP_HIT, 4'd0, 2'd0, 16'd260, 1'b0);
        send_request(OP_READ, 4'd0, 2'd0, 16'd0, 1'b0);
        send_request(OP_READ, 4'd1, 2'd0, 16'd0, 1'b0);
        send_request(OP_READ, 4'd15, 2'd0, 16'd0, 1'b0);
    endtask

    // Disabled counting, unused dimension codes, gate counts past the top
    task automatic test_register_corners();
        set_mode(1'b0, DIM_2D, GATES_W'(GATE_COUNT));
        run_traffic(60);
        set_mode(1'b1, DIM_NONE, GATES_W'(8));
        run_traffic(60);
        set_mode(1'b1, DIM_SPARE, GATES_W'(GATE_COUNT));
        run_traffic(60);
        set_mode(1'b1, DIM_2D, '1);
        run_traffic(80);
        set_mode(1'b1, DIM_1D, '0);
        run_traffic(60);
        set_mode(1'b1, DIM_1D, '1);
        run_traffic(80);
    endtask

    task automatic test_random_traffic();
        int unsigned p;
        logic [DIM_W-1:0]   dim;
        logic [GATES_W-1:0] gates;
        for (p = 0; p < 10; p++)
        begin
            idle_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            dim   = ($urandom_range(0, 7) == 0) ? DIM_W'($urandom)
                                                : (($urandom_range(0, 1) == 0) ? DIM_1D : DIM_2D);
            gates = ($urandom_range(0, 2) == 0) ? GATES_W'($urandom)
                                                : GATES_W'($urandom_range(1, GATE_COUNT));
            set_mode($urandom_range(0, 9) != 0, dim, gates);
            run_traffic(120);
        end
    endtask

    // Back-to-back requests and pops, no gaps on either side
    task automatic test_steady_stream();
        set_mode(1'b1, DIM_2D, GATES_W'(GATE_COUNT));
        idle_on  = 1'b0;
        stall_on = 1'b0;
        run_traffic(150);
        set_mode(1'b1, DIM_1D, GATES_W'(GATE_COUNT));
        run_traffic(150);
    endtask

    // ---------------- sequence ----------------

    initial
    begin : main
        rst_n          = 1'b0;
        push           = 1'b0;
        opcode         = OP_LOAD;
        gate_index     = '0;
        bound_index    = '0;
        sample_value   = '0;
        first_of_event = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_ENABLE;
        cfg_data       = '0;
        errors         = 0;
        quiet_cycles   = 0;
        idle_on        = 1'b0;
        stall_on       = 1'b0;
        count_on       = 1'b0;
        dim_cfg        = DIM_1D;
        gates_cfg      = '0;
        ev_fill        = 0;
        foreach (bounds[i]) bounds[i] = '0;
        foreach (counts[i]) counts[i] = '0;
        foreach (ev_hits[i]) ev_hits[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_one_value_gates();
        test_pair_gates();
        test_register_corners();
        test_random_traffic();
        test_steady_stream();

        wait_idle();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
